/* hw/rtl/lbr_pkg.sv */
package lbr_pkg;

  localparam int FRAME_PIXELS = 262144;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);

  localparam int DIM_W   = 10;
  localparam int DIM_MAX = 512;
  localparam int FMT_W   = 2;
  localparam int IDX_W   = 18;
  localparam int BYTE_W  = 8;
  localparam int COORD_W = 9;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  localparam int QUEUE_DEPTH = 2;

  // restoring divider: dividend covers 2*src*num+den, divisor covers 2*dim
  localparam int DIV_NUM_W = 20;
  localparam int DIV_DEN_W = DIM_W + 1;

  // pixel_format bits
  localparam int FMT_BE_BIT  = 0;
  localparam int FMT_BGR_BIT = 1;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_SRC_HEIGHT   = 3'd1,
    REG_DST_WIDTH    = 3'd2,
    REG_DST_HEIGHT   = 3'd3,
    REG_PIXEL_FORMAT = 3'd4
  } lbr_reg_e;

  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
    logic [FMT_W-1:0] fmt;
  } lbr_cfg_t;

  typedef struct packed {
    logic              is_render;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  word;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } lbr_item_t;

  typedef struct packed {
    logic idle;
    logic geom_ok;
  } lbr_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [CHAN_W-1:0] widen6(input logic [5:0] c);
    return {c, c[5:4]};
  endfunction

endpackage

/* hw/rtl/lbr_if.sv */
interface lbr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [lbr_pkg::IDX_W-1:0]     src_index;
  logic [lbr_pkg::BYTE_W-1:0]    byte_first;
  logic [lbr_pkg::BYTE_W-1:0]    byte_second;
  logic [lbr_pkg::COORD_W-1:0]   dst_x;
  logic [lbr_pkg::COORD_W-1:0]   dst_y;

  modport source (output valid, func, src_index, byte_first, byte_second, dst_x, dst_y,
                  input ready);
  modport sink (input valid, func, src_index, byte_first, byte_second, dst_x, dst_y,
                output ready);
endinterface

interface lbr_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbr_pkg::CHAN_W-1:0]  red;
  logic [lbr_pkg::CHAN_W-1:0]  green;
  logic [lbr_pkg::CHAN_W-1:0]  blue;
  logic                        is_padding;

  modport source (output valid, red, green, blue, is_padding, input ready);
  modport sink (input valid, red, green, blue, is_padding, output ready);
endinterface

/* hw/rtl/letterbox_nearest_resize_rgb565_unit.sv */
// Channel  | Dir | Handshake     | Payload
// src_i    | in  | valid/ready   | func, src_index, byte_first, byte_second, dst_x, dst_y
// res_o    | out | valid/ready   | red, green, blue, is_padding
// cfg      | in  | cfg_we_i only | cfg_index_i, cfg_wdata_i
//
// A load is written to the frame store as it leaves the queue (one frame store write port).
// A render inside the picture waits on the 20-step restoring dividers for the source
// column and row; a padding render skips them.
// The first render after a register write first rebuilds scale and borders.
// Reset clears control state and sets the registers to their defaults; the frame store is not cleared.
// A two-entry queue lets the front keep taking transactions while the back end stalls.
module letterbox_nearest_resize_rgb565_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lbr_in_if.sink                             src_i,
  lbr_out_if.source                          res_o,
  input  logic                               cfg_we_i,
  input  logic [lbr_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [lbr_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  lbr_pkg::lbr_cfg_t  cfg_q, cfg_d;
  lbr_pkg::lbr_stat_t stat;

  logic               push_valid, push_ready;
  lbr_pkg::lbr_item_t push_item;
  logic               pop_valid, pop_ready;
  lbr_pkg::lbr_item_t pop_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (lbr_pkg::lbr_reg_e'(cfg_index_i))
        lbr_pkg::REG_SRC_WIDTH:    cfg_d.src_w = lbr_pkg::clamp_dim(cfg_wdata_i);
        lbr_pkg::REG_SRC_HEIGHT:   cfg_d.src_h = lbr_pkg::clamp_dim(cfg_wdata_i);
        lbr_pkg::REG_DST_WIDTH:    cfg_d.dst_w = lbr_pkg::clamp_dim(cfg_wdata_i);
        lbr_pkg::REG_DST_HEIGHT:   cfg_d.dst_h = lbr_pkg::clamp_dim(cfg_wdata_i);
        lbr_pkg::REG_PIXEL_FORMAT: cfg_d.fmt   = cfg_wdata_i[lbr_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w <= lbr_pkg::DIM_W'(320);
      cfg_q.src_h <= lbr_pkg::DIM_W'(240);
      cfg_q.dst_w <= lbr_pkg::DIM_W'(192);
      cfg_q.dst_h <= lbr_pkg::DIM_W'(192);
      cfg_q.fmt   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lbr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (src_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  lbr_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  lbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_wr_i    (cfg_we_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .res_o       (res_o),
    .stat_o      (stat)
  );

  // any register write must drop the cached scale and borders
  a_cfg_drops_geom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !stat.geom_ok)
    else $error("geometry still marked valid after a register write");

  a_pad_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_padding |->
      res_o.red == '0 && res_o.green == '0 && res_o.blue == '0)
    else $error("padding pixel is not black");

  // a new result comes only out of the back end's emit step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(!stat.idle))
    else $error("result appeared while back end was idle");

endmodule

/* hw/rtl/lbr_front.sv */
module lbr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  lbr_in_if.sink             src_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output lbr_pkg::lbr_item_t push_item_o
);

  logic               st_valid_q, st_valid_d;
  lbr_pkg::lbr_item_t st_item_q;
  logic               accept;
  logic               in_range;
  logic               is_render;

  assign src_i.ready = !st_valid_q || push_ready_i;
  assign accept      = src_i.valid && src_i.ready;
  assign in_range    = 32'(src_i.src_index) < lbr_pkg::FRAME_PIXELS;
  assign is_render   = src_i.func == lbr_pkg::FUNC_RENDER;

  // drop loads that fall outside the frame store
  always_comb begin
    st_valid_d = st_valid_q;
    if (accept) begin
      st_valid_d = is_render || in_range;
    end else if (push_ready_i) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else begin
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_item_q.is_render <= is_render;
      st_item_q.addr      <= lbr_pkg::ADDR_W'(src_i.src_index);
      st_item_q.word      <= {src_i.byte_second, src_i.byte_first};
      st_item_q.x         <= src_i.dst_x;
      st_item_q.y         <= src_i.dst_y;
    end
  end

  assign push_valid_o = st_valid_q;
  assign push_item_o  = st_item_q;

endmodule

/* hw/rtl/lbr_fifo.sv */
module lbr_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  lbr_pkg::lbr_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output lbr_pkg::lbr_item_t pop_item_o
);

  localparam int Depth = lbr_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lbr_pkg::lbr_item_t entry_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic               push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* hw/rtl/lbr_div.sv */
module lbr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lbr_pkg::DIV_NUM_W-1:0]   dividend_i,
  input  logic [lbr_pkg::DIV_DEN_W-1:0]   divisor_i,
  output logic                            busy_o,
  output logic [lbr_pkg::DIV_NUM_W-1:0]   quotient_o
);

  localparam int NumW = lbr_pkg::DIV_NUM_W;
  localparam int DenW = lbr_pkg::DIV_DEN_W;
  localparam int CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] div_q;
  logic [DenW:0]   trial;
  logic            fits;
  logic [DenW-1:0] rem_d;

  // one quotient bit per cycle, MSB first
  assign trial = {rem_q, quo_q[NumW-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign rem_d = fits ? DenW'(trial - {1'b0, div_q}) : trial[DenW-1:0];

  assign busy_o     = cnt_q != '0;
  assign quotient_o = quo_q;

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CntW'(NumW);
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_o) begin
      quo_q <= {quo_q[NumW-2:0], fits};
      rem_q <= rem_d;
    end
  end

endmodule

/* hw/rtl/lbr_back.sv */
module lbr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbr_pkg::lbr_cfg_t  cfg_i,
  input  logic               cfg_wr_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  lbr_pkg::lbr_item_t pop_item_i,
  lbr_out_if.source          res_o,
  output lbr_pkg::lbr_stat_t stat_o
);

  localparam int DimW   = lbr_pkg::DIM_W;
  localparam int CoordW = lbr_pkg::COORD_W;
  localparam int NumW   = lbr_pkg::DIV_NUM_W;
  localparam int DenW   = lbr_pkg::DIV_DEN_W;
  localparam int AddrW  = lbr_pkg::ADDR_W;
  localparam int PixW   = lbr_pkg::PIX_W;
  localparam int ChanW  = lbr_pkg::CHAN_W;

  typedef enum logic [10:0] {
    ST_IDLE       = 11'b000_0000_0001,
    ST_RATIO      = 11'b000_0000_0010,
    ST_PICK       = 11'b000_0000_0100,
    ST_SIZE       = 11'b000_0000_1000,
    ST_SIZE_WAIT  = 11'b000_0001_0000,
    ST_BORDER     = 11'b000_0010_0000,
    ST_CLASS      = 11'b000_0100_0000,
    ST_COORD_WAIT = 11'b000_1000_0000,
    ST_ADDR       = 11'b001_0000_0000,
    ST_READ       = 11'b010_0000_0000,
    ST_EMIT       = 11'b100_0000_0000
  } lbr_state_e;

  lbr_state_e state_q, state_d;
  logic       geom_ok_q, geom_ok_d;
  logic       out_valid_q, out_valid_d;

  logic [CoordW-1:0] x_q, y_q;
  logic [2*DimW-1:0] cross_w_q, cross_h_q;
  logic [DimW-1:0]   num_q, den_q;
  logic [CoordW-1:0] bl_q, bt_q;
  logic [DimW:0]     edge_x_q, edge_y_q;
  logic              pad_q;
  logic [CoordW-1:0] sx_q, sy_q;
  logic [AddrW-1:0]  addr_q;
  logic              rd_ok_q;
  logic [PixW-1:0]   rdata_q;
  logic [ChanW-1:0]  red_q, green_q, blue_q;
  logic              is_pad_q;

  logic [PixW-1:0]   frame_store_q [lbr_pkg::FRAME_PIXELS];

  logic              out_free;
  logic              take_load;
  logic              div_start;
  logic [NumW-1:0]   div_num_x, div_num_y;
  logic [DenW-1:0]   div_den;
  logic              busy_x, busy_y;
  logic [NumW-1:0]   quot_x, quot_y;

  logic [2*DimW-1:0] size_w, size_h;
  logic [DimW-1:0]   sw_c, sh_c;
  logic [DimW-1:0]   gap_w, gap_h;
  logic [CoordW-1:0] u_x, u_y;
  logic [2*DimW-1:0] mul_x, mul_y;
  logic              pad_c;
  logic [DimW-1:0]   lim_x, lim_y;
  logic [CoordW-1:0] sx_c, sy_c;
  logic [2*DimW-1:0] idx_c;
  logic [PixW-1:0]   word, pix;
  logic [ChanW-1:0]  c0, c1, c2;

  assign out_free  = !out_valid_q || res_o.ready;
  assign pop_ready_o = state_q == ST_IDLE;
  assign take_load = (state_q == ST_IDLE) && pop_valid_i && !pop_item_i.is_render;

  // scaled size: round(src * num / den) as (2*src*num + den) / (2*den)
  assign size_w = cfg_i.src_w * num_q;
  assign size_h = cfg_i.src_h * num_q;

  // nearest source coordinate: floor((2u+1) * den / (2*num))
  assign u_x   = x_q - bl_q;
  assign u_y   = y_q - bt_q;
  assign mul_x = {u_x, 1'b1} * den_q;
  assign mul_y = {u_y, 1'b1} * den_q;

  assign div_start = (state_q == ST_SIZE) || ((state_q == ST_CLASS) && !pad_c);

  always_comb begin
    if (state_q == ST_SIZE) begin
      div_num_x = NumW'({size_w, 1'b0}) + NumW'(den_q);
      div_num_y = NumW'({size_h, 1'b0}) + NumW'(den_q);
      div_den   = {den_q, 1'b0};
    end else begin
      div_num_x = NumW'(mul_x);
      div_num_y = NumW'(mul_y);
      div_den   = {num_q, 1'b0};
    end
  end

  lbr_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num_x),
    .divisor_i  (div_den),
    .busy_o     (busy_x),
    .quotient_o (quot_x)
  );

  lbr_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num_y),
    .divisor_i  (div_den),
    .busy_o     (busy_y),
    .quotient_o (quot_y)
  );

  // scaled size never exceeds the destination size, so the gap is never negative
  assign sw_c  = (quot_x[DimW-1:0] == '0) ? DimW'(1) : quot_x[DimW-1:0];
  assign sh_c  = (quot_y[DimW-1:0] == '0) ? DimW'(1) : quot_y[DimW-1:0];
  assign gap_w = cfg_i.dst_w - sw_c;
  assign gap_h = cfg_i.dst_h - sh_c;

  assign pad_c = (x_q < bl_q) || ((DimW + 1)'(x_q) >= edge_x_q) ||
                 (y_q < bt_q) || ((DimW + 1)'(y_q) >= edge_y_q);

  assign lim_x = cfg_i.src_w - 1'b1;
  assign lim_y = cfg_i.src_h - 1'b1;
  assign sx_c  = (quot_x > NumW'(lim_x)) ? lim_x[CoordW-1:0] : quot_x[CoordW-1:0];
  assign sy_c  = (quot_y > NumW'(lim_y)) ? lim_y[CoordW-1:0] : quot_y[CoordW-1:0];

  assign idx_c = sy_q * cfg_i.src_w + (2 * DimW)'(sx_q);

  // format the fetched word: byte swap for big endian, channel swap for BGR
  assign word = rd_ok_q ? rdata_q : '0;
  assign pix  = cfg_i.fmt[lbr_pkg::FMT_BE_BIT] ? {word[7:0], word[15:8]} : word;
  assign c0   = lbr_pkg::widen5(pix[15:11]);
  assign c1   = lbr_pkg::widen6(pix[10:5]);
  assign c2   = lbr_pkg::widen5(pix[4:0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i && pop_item_i.is_render) begin
          state_d = geom_ok_q ? ST_CLASS : ST_RATIO;
        end
      end
      ST_RATIO:     state_d = ST_PICK;
      ST_PICK:      state_d = ST_SIZE;
      ST_SIZE:      state_d = ST_SIZE_WAIT;
      ST_SIZE_WAIT: begin
        if (!busy_x && !busy_y) begin
          state_d = ST_BORDER;
        end
      end
      ST_BORDER:    state_d = ST_CLASS;
      ST_CLASS:     state_d = pad_c ? ST_EMIT : ST_COORD_WAIT;
      ST_COORD_WAIT: begin
        if (!busy_x && !busy_y) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR:      state_d = ST_READ;
      ST_READ:      state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // a register write drops the cached geometry
  always_comb begin
    geom_ok_d = geom_ok_q;
    if (cfg_wr_i) begin
      geom_ok_d = 1'b0;
    end else if (state_q == ST_BORDER) begin
      geom_ok_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == ST_EMIT) && out_free) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      geom_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      geom_ok_q   <= geom_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i && pop_item_i.is_render) begin
          x_q <= pop_item_i.x;
          y_q <= pop_item_i.y;
        end
      end
      ST_RATIO: begin
        cross_w_q <= cfg_i.dst_w * cfg_i.src_h;
        cross_h_q <= cfg_i.dst_h * cfg_i.src_w;
      end
      ST_PICK: begin
        if (cross_w_q <= cross_h_q) begin
          num_q <= cfg_i.dst_w;
          den_q <= cfg_i.src_w;
        end else begin
          num_q <= cfg_i.dst_h;
          den_q <= cfg_i.src_h;
        end
      end
      ST_BORDER: begin
        bl_q     <= gap_w[DimW-1:1];
        bt_q     <= gap_h[DimW-1:1];
        edge_x_q <= (DimW + 1)'(gap_w[DimW-1:1]) + (DimW + 1)'(sw_c);
        edge_y_q <= (DimW + 1)'(gap_h[DimW-1:1]) + (DimW + 1)'(sh_c);
      end
      ST_CLASS: begin
        pad_q <= pad_c;
      end
      ST_COORD_WAIT: begin
        sx_q <= sx_c;
        sy_q <= sy_c;
      end
      ST_ADDR: begin
        addr_q  <= AddrW'(idx_c);
        rd_ok_q <= 32'(idx_c) < lbr_pkg::FRAME_PIXELS;
      end
      ST_EMIT: begin
        if (out_free) begin
          is_pad_q <= pad_q;
          if (pad_q) begin
            red_q   <= '0;
            green_q <= '0;
            blue_q  <= '0;
          end else begin
            red_q   <= cfg_i.fmt[lbr_pkg::FMT_BGR_BIT] ? c2 : c0;
            green_q <= c1;
            blue_q  <= cfg_i.fmt[lbr_pkg::FMT_BGR_BIT] ? c0 : c2;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take_load) begin
      frame_store_q[pop_item_i.addr] <= pop_item_i.word;
    end
    if (state_q == ST_READ) begin
      rdata_q <= frame_store_q[addr_q];
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.red        = red_q;
  assign res_o.green      = green_q;
  assign res_o.blue       = blue_q;
  assign res_o.is_padding = is_pad_q;

  assign stat_o.idle    = state_q == ST_IDLE;
  assign stat_o.geom_ok = geom_ok_q;

endmodule
